FILE: rtl/ibdi_pkg.sv
// Package for the diagonal inter-burst interleaver.
// Holds default sizes, field widths, register indexes and a width helper.
// Used by ibdi_ram and inter_burst_diagonal_interleaver; depends on nothing.
`default_nettype none

package ibdi_pkg;

	// Default store dimensions (rows by columns)
	localparam int DEF_MAX_DEPTH = 8;
	localparam int DEF_MAX_WIDTH = 1024;

	// Field widths
	localparam int SAMPLE_W = 8;
	localparam int DEPTH_W  = 4;
	localparam int WIDTH_W  = 11;

	// Configuration port
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;
	localparam int REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_DIRECTION = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_DEPTH     = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_WIDTH     = 2'd2;

	// Direction codes
	localparam logic DIR_INTERLEAVE   = 1'b0;
	localparam logic DIR_DEINTERLEAVE = 1'b1;

	// Bits needed to index a range of the given size, at least one
	function automatic int clog2_min1(input int size);
		return (size > 1) ? $clog2(size) : 1;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/ibdi_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Read data holds while no read is issued. Depends on ibdi_pkg for clog2_min1.
`default_nettype none

module ibdi_ram
	import ibdi_pkg::*;
#(
	parameter int DATA_W = SAMPLE_W,
	parameter int DEPTH  = DEF_MAX_DEPTH * DEF_MAX_WIDTH,
	localparam int ADDR_W = clog2_min1(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, held between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/inter_burst_diagonal_interleaver.sv
// Diagonal inter-burst interleaver / deinterleaver over a MAX_DEPTH x MAX_WIDTH sample store.
// An accepted item goes into stage 1 with its store read, then into the output register;
// throughput one item per cycle while not stalled, set by one store write and read per cycle.
// Reset: counters and registers go to their defaults, then a clearing pass writes zero to
// all MAX_DEPTH*MAX_WIDTH store entries (8192 at defaults), while sample_stall is high.
// Depends on ibdi_pkg and ibdi_ram.
`default_nettype none

module inter_burst_diagonal_interleaver
	import ibdi_pkg::*;
#(
	parameter int MAX_DEPTH = DEF_MAX_DEPTH,
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// Configuration port
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [PADDR_W-1:0]  paddr,
	input  wire logic [PDATA_W-1:0]  pwdata,
	output logic      [PDATA_W-1:0]  prdata,
	output logic                     pready,
	// Input channel
	input  wire logic                sample_valid,
	output logic                     sample_stall,
	input  wire logic [SAMPLE_W-1:0] sample_in,
	// Result channel
	output logic                     result_valid,
	input  wire logic                result_stall,
	output logic      [SAMPLE_W-1:0] sample_out,
	output logic                     burst_end
);

	localparam int MEM_DEPTH = MAX_DEPTH * MAX_WIDTH;
	localparam int ADDR_W    = clog2_min1(MEM_DEPTH);
	localparam int ROW_W     = (MAX_DEPTH > 16) ? DEPTH_W : clog2_min1(MAX_DEPTH);
	localparam int COL_W     = clog2_min1(MAX_WIDTH);
	localparam int RSUM_W    = DEPTH_W + 1;
	localparam int CCMP_W    = ((COL_W > WIDTH_W) ? COL_W : WIDTH_W) + 1;

	// Configuration registers
	logic               direction_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [WIDTH_W-1:0] width_q;

	// Position counters
	logic [ROW_W-1:0] burst_row_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] col_mod_q;

	// Clearing pass
	logic              clearing_q;
	logic [ADDR_W-1:0] clr_addr_q;

	// Pipeline
	logic                valid_s1;
	logic                bypass_s1;
	logic                last_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                out_valid_q;
	logic                out_last_q;
	logic [SAMPLE_W-1:0] out_sample_q;

	logic                cfg_write;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                reg_hit;
	logic [DEPTH_W-1:0]  depth_wr;
	logic [WIDTH_W-1:0]  width_wr;

	logic                sample_accept;
	logic                out_free;
	logic [ROW_W-1:0]    diag_row;
	logic [ROW_W-1:0]    next_row;
	logic [ROW_W-1:0]    next_col_mod;
	logic [ROW_W-1:0]    wr_row;
	logic [ROW_W-1:0]    rd_row;
	logic                last_col;
	logic                bypass;
	logic [ADDR_W-1:0]   item_waddr;
	logic [ADDR_W-1:0]   item_raddr;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [SAMPLE_W-1:0] ram_wdata;
	logic [SAMPLE_W-1:0] ram_rdata;

	// Configuration decode and clamping
	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite & pready;
	assign reg_idx   = paddr[PADDR_W-1:2];
	assign reg_hit   = (reg_idx == REG_DIRECTION) || (reg_idx == REG_DEPTH)
		|| (reg_idx == REG_WIDTH);

	always_comb begin
		depth_wr = pwdata[DEPTH_W-1:0];
		if (depth_wr == '0) begin
			depth_wr = DEPTH_W'(1);
		end else if (int'(depth_wr) > MAX_DEPTH) begin
			depth_wr = DEPTH_W'(MAX_DEPTH);
		end
		width_wr = pwdata[WIDTH_W-1:0];
		if (width_wr == '0) begin
			width_wr = WIDTH_W'(1);
		end else if (int'(width_wr) > MAX_WIDTH) begin
			width_wr = WIDTH_W'(MAX_WIDTH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_INTERLEAVE;
			depth_q     <= DEPTH_W'(1);
			width_q     <= WIDTH_W'(1);
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_DIRECTION: direction_q <= pwdata[0];
				REG_DEPTH:     depth_q     <= depth_wr;
				REG_WIDTH:     width_q     <= width_wr;
				default:       ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		unique case (reg_idx)
			REG_DIRECTION: prdata = PDATA_W'(direction_q);
			REG_DEPTH:     prdata = PDATA_W'(depth_q);
			REG_WIDTH:     prdata = PDATA_W'(width_q);
			default:       prdata = '0;
		endcase
	end

	// Handshake: the output register frees the pipeline when empty or being taken
	assign out_free      = !out_valid_q || !result_stall;
	assign sample_stall  = clearing_q || (valid_s1 && !out_free);
	assign sample_accept = sample_valid && !sample_stall;

	// Row arithmetic: diagonal row, next burst row, next column phase
	always_comb begin
		if (col_mod_q <= burst_row_q) begin
			diag_row = burst_row_q - col_mod_q;
		end else begin
			diag_row = ROW_W'(RSUM_W'(burst_row_q) + RSUM_W'(depth_q) - RSUM_W'(col_mod_q));
		end
		if (RSUM_W'(burst_row_q) + RSUM_W'(1) == RSUM_W'(depth_q)) begin
			next_row = '0;
		end else begin
			next_row = ROW_W'(RSUM_W'(burst_row_q) + RSUM_W'(1));
		end
		if (RSUM_W'(col_mod_q) + RSUM_W'(1) == RSUM_W'(depth_q)) begin
			next_col_mod = '0;
		end else begin
			next_col_mod = ROW_W'(RSUM_W'(col_mod_q) + RSUM_W'(1));
		end
	end

	// Pick write and read rows for the direction
	always_comb begin
		unique case (direction_q)
			DIR_INTERLEAVE: begin
				wr_row = burst_row_q;
				rd_row = diag_row;
			end
			DIR_DEINTERLEAVE: begin
				wr_row = diag_row;
				rd_row = next_row;
			end
			default: begin
				wr_row = burst_row_q;
				rd_row = diag_row;
			end
		endcase
	end

	assign bypass     = (wr_row == rd_row);
	assign last_col   = (CCMP_W'(col_q) + CCMP_W'(1)) >= CCMP_W'(width_q);
	assign item_waddr = ADDR_W'(ADDR_W'(wr_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_q));
	assign item_raddr = ADDR_W'(ADDR_W'(rd_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_q));

	// Advance burst row and column per item; restart on any register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_row_q <= '0;
			col_q       <= '0;
			col_mod_q   <= '0;
		end else if (cfg_write && reg_hit) begin
			burst_row_q <= '0;
			col_q       <= '0;
			col_mod_q   <= '0;
		end else if (sample_accept) begin
			if (last_col) begin
				burst_row_q <= next_row;
				col_q       <= '0;
				col_mod_q   <= '0;
			end else begin
				col_q       <= col_q + COL_W'(1);
				col_mod_q   <= next_col_mod;
			end
		end
	end

	// Sweep the store with zeros after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (clr_addr_q == ADDR_W'(MEM_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Write port: clearing sweep or the accepted item
	assign ram_we    = clearing_q || sample_accept;
	assign ram_waddr = clearing_q ? clr_addr_q : item_waddr;
	assign ram_wdata = clearing_q ? '0 : sample_in;

	ibdi_ram #(
		.DATA_W (SAMPLE_W),
		.DEPTH  (MEM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (sample_accept),
		.raddr (item_raddr),
		.rdata (ram_rdata)
	);

	// Stage 1: wait for read data, hold while the output register is full and stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_accept) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_accept) begin
			bypass_s1 <= bypass;
			last_s1   <= last_col;
			sample_s1 <= sample_in;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			out_sample_q <= bypass_s1 ? sample_s1 : ram_rdata;
			out_last_q   <= last_s1;
		end
	end

	assign result_valid = out_valid_q;
	assign sample_out   = out_sample_q;
	assign burst_end    = out_last_q;

`ifndef NO_ASSERTIONS
	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		RSUM_W'(burst_row_q) < RSUM_W'(depth_q))
		else $error("burst row reached depth");

	a_col_mod_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		RSUM_W'(col_mod_q) < RSUM_W'(depth_q))
		else $error("column phase reached depth");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		CCMP_W'(col_q) < CCMP_W'(width_q))
		else $error("column index reached burst width");

	a_col_mod_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q == '0) |-> (col_mod_q == '0))
		else $error("column phase not zero at burst start");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		sample_accept |=> valid_s1)
		else $error("accepted item lost before stage 1");
`endif

endmodule

`default_nettype wire
